// ===== hw/rtl/mrwt_pkg.sv =====
package mrwt_pkg;

    localparam int DEF_WIDTH = 64;
    localparam int FIELD_W   = 64;
    localparam int QDEPTH    = 2;

    typedef struct packed {
        logic [FIELD_W-1:0] candidate;
        logic [FIELD_W-1:0] witness;
    } in_item_t;

    typedef struct packed {
        logic probable_prime;
        logic trivially_decided;
    } out_item_t;

    // entry passed from front to back: trivial verdict or work to do
    typedef struct packed {
        logic               trivial;
        logic               verdict;
        logic [FIELD_W-1:0] p;
        logic [FIELD_W-1:0] a;
    } task_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SPLIT,
        ST_POW_SQ,
        ST_POW_MUL,
        ST_POW_NEXT,
        ST_LOOP_SQ,
        ST_LOOP_CHK,
        ST_DONE
    } back_state_t;

    typedef enum logic [1:0] {
        MM_IDLE,
        MM_RUN,
        MM_FIN
    } mm_state_t;

endpackage

// ===== hw/rtl/mrwt_modmul.sv =====
module mrwt_modmul #(
    parameter int WIDTH = mrwt_pkg::DEF_WIDTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] x,
    input  logic [WIDTH-1:0] y,
    input  logic [WIDTH-1:0] m,
    output logic             done,
    output logic [WIDTH-1:0] r
);
    import mrwt_pkg::*;

    localparam int CW = $clog2(WIDTH);

    mm_state_t        state_reg, state_next;
    logic [WIDTH-1:0] r_reg, r_next;
    logic [WIDTH-1:0] x_reg, y_reg, m_reg;
    logic [CW-1:0]    bit_reg, bit_next;
    logic [WIDTH:0]   dbl, dbl_red, add, add_red;
    logic             load;

    // one bit per cycle: r = 2r mod m, then add x if bit set
    always_comb
    begin
        dbl     = {r_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, m_reg}) ? dbl - {1'b0, m_reg} : dbl;
        add     = dbl_red + {1'b0, x_reg};
        add_red = (add >= {1'b0, m_reg}) ? add - {1'b0, m_reg} : add;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            MM_IDLE: if (start) state_next = MM_RUN;
            MM_RUN:  if (bit_reg == '0) state_next = MM_FIN;
            MM_FIN:  state_next = MM_IDLE;
            default: state_next = MM_IDLE;
        endcase
    end

    always_comb
    begin
        load     = 1'b0;
        r_next   = r_reg;
        bit_next = bit_reg;
        case (state_reg)
            MM_IDLE:
            begin
                load     = start;
                r_next   = '0;
                bit_next = CW'(WIDTH - 1);
            end
            MM_RUN:
            begin
                r_next   = y_reg[bit_reg] ? add_red[WIDTH-1:0] : dbl_red[WIDTH-1:0];
                bit_next = bit_reg - 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MM_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg   <= r_next;
        bit_reg <= bit_next;
        if (load)
        begin
            x_reg <= x;
            y_reg <= y;
            m_reg <= m;
        end
    end

    assign done = (state_reg == MM_FIN);
    assign r    = r_reg;

endmodule

// ===== hw/rtl/mrwt_front.sv =====
module mrwt_front #(
    parameter int WIDTH = mrwt_pkg::DEF_WIDTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  mrwt_pkg::in_item_t  in_item,
    output logic                q_empty,
    input  logic                q_pop,
    output mrwt_pkg::task_t     q_head
);
    import mrwt_pkg::*;

    localparam int PW = $clog2(QDEPTH);

    task_t            mem [QDEPTH];
    logic [PW-1:0]    wp_reg, rp_reg;
    logic [PW:0]      cnt_reg, cnt_next;
    logic [WIDTH-1:0] p, a;
    logic             is_small, is_prime_small;
    task_t            t;
    logic             do_push, do_pop;

    always_comb
    begin
        p              = in_item.candidate[WIDTH-1:0];
        a              = in_item.witness[WIDTH-1:0];
        is_prime_small = (p == WIDTH'(2)) || (p == WIDTH'(3)) || (p == WIDTH'(5));
        is_small       = (p < WIDTH'(2)) || (p != WIDTH'(2) && !p[0]) || is_prime_small;
        t              = '0;
        t.trivial      = is_small;
        t.verdict      = is_prime_small;
        t.p            = FIELD_W'(p);
        t.a            = FIELD_W'(a);
    end

    assign full    = (cnt_reg == (PW+1)'(QDEPTH));
    assign q_empty = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = q_pop && !q_empty;
    assign q_head  = mem[rp_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop) cnt_next = cnt_reg + 1'b1;
        if (!do_push && do_pop) cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push) wp_reg <= wp_reg + 1'b1;
            if (do_pop)  rp_reg <= rp_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) mem[wp_reg] <= t;
    end

endmodule

// ===== hw/rtl/mrwt_back.sv =====
module mrwt_back #(
    parameter int WIDTH = mrwt_pkg::DEF_WIDTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    output logic                q_pop,
    input  mrwt_pkg::task_t     q_head,
    output logic                empty,
    input  logic                pop,
    output mrwt_pkg::out_item_t out_item
);
    import mrwt_pkg::*;

    localparam int CW = $clog2(WIDTH);

    back_state_t      state_reg, state_next;
    logic [WIDTH-1:0] p_reg, p_next, a_reg, a_next, d_reg, d_next, x_reg, x_next;
    logic [CW:0]      s_reg, s_next;
    logic [CW-1:0]    bit_reg, bit_next;
    logic             nt_reg, nt_next;
    logic             ov_reg, ov_next;
    out_item_t        res_reg, res_next;
    logic             mm_start, mm_done;
    logic [WIDTH-1:0] mm_x, mm_y, mm_r, pm1;
    logic             take;

    mrwt_modmul #(.WIDTH(WIDTH)) u_mm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mm_start),
        .x     (mm_x),
        .y     (mm_y),
        .m     (p_reg),
        .done  (mm_done),
        .r     (mm_r)
    );

    assign pm1   = p_reg - 1'b1;
    assign empty = !ov_reg;
    assign take  = pop && ov_reg;
    assign out_item = res_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (!q_empty && (!ov_reg || take))
                    state_next = q_head.trivial ? ST_IDLE : ST_REDUCE;
            ST_REDUCE:   if (mm_done) state_next = ST_SPLIT;
            ST_SPLIT:    if (d_reg[0]) state_next = ST_POW_SQ;
            ST_POW_SQ:   if (mm_done) state_next = d_reg[bit_reg] ? ST_POW_MUL : ST_POW_NEXT;
            ST_POW_MUL:  if (mm_done) state_next = ST_POW_NEXT;
            ST_POW_NEXT: state_next = (bit_reg == '0) ? ST_LOOP_CHK : ST_POW_SQ;
            ST_LOOP_SQ:  if (mm_done) state_next = ST_LOOP_CHK;
            ST_LOOP_CHK: state_next = ST_DONE;
            ST_DONE:     if (!ov_reg || take) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
        if (state_reg == ST_LOOP_CHK)
        begin
            if (s_reg != '0 && !(x_reg == WIDTH'(1) && nt_reg))
                state_next = ST_LOOP_SQ;
        end
    end

    always_comb
    begin
        p_next   = p_reg;
        a_next   = a_reg;
        d_next   = d_reg;
        x_next   = x_reg;
        s_next   = s_reg;
        bit_next = bit_reg;
        nt_next  = nt_reg;
        res_next = res_reg;
        ov_next  = ov_reg;
        q_pop    = 1'b0;
        mm_start = 1'b0;
        mm_x     = x_reg;
        mm_y     = x_reg;
        if (take) ov_next = 1'b0;
        case (state_reg)
            ST_IDLE:
                if (!q_empty && (!ov_reg || take))
                begin
                    q_pop  = 1'b1;
                    p_next = q_head.p[WIDTH-1:0];
                    a_next = q_head.a[WIDTH-1:0];
                    d_next = q_head.p[WIDTH-1:0] - 1'b1;
                    s_next = '0;
                    nt_next = 1'b0;
                    if (q_head.trivial)
                    begin
                        res_next.probable_prime    = q_head.verdict;
                        res_next.trivially_decided = 1'b1;
                        ov_next = 1'b1;
                    end
                end
            ST_REDUCE:
            begin
                // a mod p as a*1 mod p, valid since 2r+1 stays in range
                mm_x     = WIDTH'(1);
                mm_y     = a_reg;
                mm_start = 1'b1;
                if (mm_done)
                begin
                    a_next   = mm_r;
                    x_next   = WIDTH'(1);
                    bit_next = CW'(WIDTH - 1);
                end
            end
            ST_SPLIT:
                if (!d_reg[0])
                begin
                    d_next = d_reg >> 1;
                    s_next = s_reg + 1'b1;
                end
            ST_POW_SQ:
            begin
                mm_start = 1'b1;
                if (mm_done) x_next = mm_r;
            end
            ST_POW_MUL:
            begin
                mm_y     = a_reg;
                mm_start = 1'b1;
                if (mm_done) x_next = mm_r;
            end
            ST_POW_NEXT:
                bit_next = bit_reg - 1'b1;
            ST_LOOP_SQ:
            begin
                mm_start = 1'b1;
                if (mm_done)
                begin
                    nt_next = (x_reg != WIDTH'(1)) && (x_reg != pm1);
                    x_next  = mm_r;
                    s_next  = s_reg - 1'b1;
                end
            end
            ST_LOOP_CHK:
                if (!(s_reg != '0 && !(x_reg == WIDTH'(1) && nt_reg)))
                begin
                    res_next.probable_prime    = (x_reg == WIDTH'(1)) && !nt_reg;
                    res_next.trivially_decided = 1'b0;
                end
            ST_DONE:
                if (!ov_reg || take) ov_next = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg   <= p_next;
        a_reg   <= a_next;
        d_reg   <= d_next;
        x_reg   <= x_next;
        s_reg   <= s_next;
        bit_reg <= bit_next;
        nt_reg  <= nt_next;
        res_reg <= res_next;
    end

endmodule

// ===== hw/rtl/miller_rabin_witness_test_top.sv =====
// one-witness primality test, queue-style channels on both sides
// input: drive in_item and raise push; a beat is taken when push is high
// and full is low. candidate and witness use their low WIDTH bits
// output: while empty is low out_item holds the oldest verdict; a beat
// leaves when pop is high and empty is low
// a two-entry queue sits between the classifier and the arithmetic engine
// small and even candidates: verdict held in the queue, then in the
// result register; one beat per cycle while pop stays high and the engine is idle
// other candidates: one shift-add modular multiplier; a reduction, one
// squaring per exponent bit, one product per set bit of d and up to s
// squarings after, at most 2*WIDTH+1 products plus control steps
// verdicts come out in input order, one item in the engine at a time
// if pop stays low the result register holds its beat, the engine stops
// at its end, the queue fills and full rises
// reset empties the queue and drops any pending result
module miller_rabin_witness_test_top #(
    parameter int WIDTH = mrwt_pkg::DEF_WIDTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  mrwt_pkg::in_item_t  in_item,
    output logic                empty,
    input  logic                pop,
    output mrwt_pkg::out_item_t out_item
);
    import mrwt_pkg::*;

    logic  q_empty, q_pop;
    task_t q_head;

    mrwt_front #(.WIDTH(WIDTH)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .in_item (in_item),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .q_head  (q_head)
    );

    mrwt_back #(.WIDTH(WIDTH)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .q_head   (q_head),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item)
    );

endmodule

// ===== hw/rtl/mrwt_checker.sv =====
module mrwt_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                push,
    input logic                full,
    input logic                empty,
    input logic                pop,
    input mrwt_pkg::out_item_t out_item
);
    // a waiting result holds until popped
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_item)))
        else $error("result changed while stalled");

    // full never rises without an input beat
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (!full && !push) |=> !full)
        else $error("full rose without a beat");

    // a waiting result carries known bits
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !$isunknown(out_item))
        else $error("unknown result bits");

    // nothing waits right after reset
    a_reset: assert property (@(posedge clk)
        !rst_n |=> empty)
        else $error("result pending after reset");

endmodule

bind miller_rabin_witness_test_top mrwt_checker u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
);
